// ----- hdl/swud_pkg.sv -----
// shared types, constants and saturating arithmetic for the sparse weight update/dot block
`timescale 1ns / 1ps

package swud_pkg;

    // widths of the stream fields and internal words
    localparam int unsigned IDX_W      = 16;
    localparam int unsigned DEPTH      = 1 << IDX_W;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned ACC_W      = 64;
    localparam int unsigned REG_W      = 31;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned MUL_W      = WORD_W + 1;
    localparam int unsigned PROD_W     = 2 * MUL_W;
    localparam int unsigned WIDE_W     = PROD_W + WORD_W;
    localparam int unsigned SHR_W      = WIDE_W - FRAC_W;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_DATA_W   = IDX_W + 2 * WORD_W;

    // register reset values, 1.0 in Q15.16
    localparam logic [REG_W-1:0] SCALE_RESET     = REG_W'(65536);
    localparam logic [REG_W-1:0] INV_SCALE_RESET = REG_W'(65536);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE = CFG_IDX_W'(1);

    // operation and result kind codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_DOT    = 1'b1;
    localparam logic KIND_DOT  = 1'b0;
    localparam logic KIND_NORM = 1'b1;

    typedef logic signed [ACC_W-1:0] acc_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_SQ_ACC,
        ST_STEP_ACC,
        ST_W_LO,
        ST_W_HI,
        ST_W_FIN,
        ST_WRITE,
        ST_NORM_U,
        ST_NORM_V,
        ST_NORM_ACC,
        ST_DOT_OUT
    } swud_state_t;

    // signed 64-bit add with saturation
    function automatic acc_t sat_add64(input acc_t a, input acc_t b);
        logic signed [ACC_W:0] sum;
        sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return sum[ACC_W-1:0];
    endfunction

    // clamp a 65-bit signed sum to a 32-bit weight
    function automatic logic [WORD_W-1:0] sat32(input logic signed [ACC_W:0] x);
        logic [ACC_W-WORD_W+1:0] hi;
        hi = x[ACC_W:WORD_W-1];
        if ((&hi) || (~|hi)) begin
            return x[WORD_W-1:0];
        end
        return x[ACC_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

    // floor shift of a wide exact product by the fraction width, saturated to 64 bits
    function automatic acc_t shr_sat(input logic signed [WIDE_W-1:0] full);
        logic [SHR_W-1:0]       q;
        logic [SHR_W-ACC_W:0]   hi;
        q  = full[WIDE_W-1:FRAC_W];
        hi = q[SHR_W-1:ACC_W-1];
        if ((&hi) || (~|hi)) begin
            return q[ACC_W-1:0];
        end
        return q[SHR_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    endfunction

endpackage

// ----- hdl/sparse_weight_update_dot_top.sv -----
// sparse weight update / dot block: scaled weight memory with sequenced shared multiplier
// steps: inner-product item DOT_MUL, DOT_ACC; update item also SQ_ACC, STEP_ACC, wide multiply,
//   WRITE; a last item then runs one (inner product) or three (norm) wide multiplies for its result
// throughput: one request at a time, rate set by the single shared 33x33 multiplier and
//   the two-pass wide product on it; memory written before the next request is taken
// reset: synchronous active-low; a clearing pass then zeroes every word of the weight memory,
//   during which no request is taken (configuration writes still are)
`timescale 1ns / 1ps

module sparse_weight_update_dot_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [swud_pkg::S_DATA_W-1:0]     s_tdata,   // index[15:0], value[47:16], multiplier[79:48]
    input  logic                              s_tuser,   // operation[0]
    input  logic                              s_tlast,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [swud_pkg::ACC_W-1:0]        m_tdata,   // result[63:0]
    output logic                              m_tuser,   // result_kind[0]
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swud_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swud_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int unsigned IDX_W  = swud_pkg::IDX_W;
    localparam int unsigned WORD_W = swud_pkg::WORD_W;
    localparam int unsigned ACC_W  = swud_pkg::ACC_W;
    localparam int unsigned REG_W  = swud_pkg::REG_W;
    localparam int unsigned MUL_W  = swud_pkg::MUL_W;
    localparam int unsigned PROD_W = swud_pkg::PROD_W;
    localparam int unsigned WIDE_W = swud_pkg::WIDE_W;
    localparam int unsigned FRAC_W = swud_pkg::FRAC_W;

    // weight memory
    logic [WORD_W-1:0] weight_mem [swud_pkg::DEPTH];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [WORD_W-1:0] rd_data_reg;

    // sequencer
    swud_pkg::swud_state_t state_reg, state_next;
    swud_pkg::swud_state_t ret_reg, ret_next;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;

    // latched request
    logic                     op_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [WORD_W-1:0] val_reg;
    logic signed [WORD_W-1:0] mulf_reg;
    logic                     last_reg;

    // multiplier and wide product datapath
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] wlo_reg, wlo_next;
    logic signed [MUL_W-1:0]  opa_reg, opa_next;
    swud_pkg::acc_t           opb_reg, opb_next;
    swud_pkg::acc_t           wres_reg, wres_next;
    swud_pkg::acc_t           two_reg, two_next;
    logic signed [WIDE_W-1:0] wide_sum;

    // accumulators and norm
    swud_pkg::acc_t dot_reg, dot_next;
    swud_pkg::acc_t sq_reg, sq_next;
    swud_pkg::acc_t norm_reg, norm_next;
    swud_pkg::acc_t dot_sum;

    // configuration registers
    logic [REG_W-1:0] scale_reg, inv_reg;

    // result register
    logic           out_valid_reg, out_valid_next;
    swud_pkg::acc_t out_data_reg, out_data_next;
    logic           out_kind_reg, out_kind_next;
    logic           out_free;
    logic           accept;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_kind_reg;

    // exact sum of the two partial products of the wide multiply
    assign wide_sum = $signed({prod_reg, {WORD_W{1'b0}}})
                    + $signed({{WORD_W{wlo_reg[PROD_W-1]}}, wlo_reg});

    // dot sum including the current product
    assign dot_sum = swud_pkg::sat_add64(dot_reg, prod_reg[ACC_W-1:0]);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            swud_pkg::ST_CLEAR: begin
                if (&clr_cnt_reg) state_next = swud_pkg::ST_IDLE;
            end
            swud_pkg::ST_IDLE: begin
                if (accept) state_next = swud_pkg::ST_DOT_MUL;
            end
            swud_pkg::ST_DOT_MUL: state_next = swud_pkg::ST_DOT_ACC;
            swud_pkg::ST_DOT_ACC: begin
                if (op_reg == swud_pkg::OP_UPDATE) state_next = swud_pkg::ST_SQ_ACC;
                else if (last_reg)                 state_next = swud_pkg::ST_W_LO;
                else                               state_next = swud_pkg::ST_IDLE;
            end
            swud_pkg::ST_SQ_ACC:   state_next = swud_pkg::ST_STEP_ACC;
            swud_pkg::ST_STEP_ACC: state_next = swud_pkg::ST_W_LO;
            swud_pkg::ST_W_LO:     state_next = swud_pkg::ST_W_HI;
            swud_pkg::ST_W_HI:     state_next = swud_pkg::ST_W_FIN;
            swud_pkg::ST_W_FIN:    state_next = ret_reg;
            swud_pkg::ST_WRITE: begin
                state_next = last_reg ? swud_pkg::ST_W_LO : swud_pkg::ST_IDLE;
            end
            swud_pkg::ST_NORM_U:   state_next = swud_pkg::ST_W_LO;
            swud_pkg::ST_NORM_V:   state_next = swud_pkg::ST_W_LO;
            swud_pkg::ST_NORM_ACC,
            swud_pkg::ST_DOT_OUT: begin
                if (out_free) state_next = swud_pkg::ST_IDLE;
            end
            default: state_next = swud_pkg::ST_IDLE;
        endcase
    end

    // handshake, memory port and multiplier operands
    always_comb begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = swud_pkg::sat32({{(ACC_W-WORD_W+1){rd_data_reg[WORD_W-1]}}, rd_data_reg}
                                    + {wres_reg[ACC_W-1], wres_reg});
        mem_re    = accept;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            swud_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            swud_pkg::ST_IDLE: s_tready = 1'b1;
            swud_pkg::ST_DOT_MUL: begin
                mul_a = {rd_data_reg[WORD_W-1], rd_data_reg};
                mul_b = {val_reg[WORD_W-1], val_reg};
            end
            swud_pkg::ST_DOT_ACC: begin
                mul_a = {val_reg[WORD_W-1], val_reg};
                mul_b = {val_reg[WORD_W-1], val_reg};
            end
            swud_pkg::ST_SQ_ACC: begin
                mul_a = {mulf_reg[WORD_W-1], mulf_reg};
                mul_b = {val_reg[WORD_W-1], val_reg};
            end
            swud_pkg::ST_W_LO: begin
                mul_a = opa_reg;
                mul_b = {1'b0, opb_reg[WORD_W-1:0]};
            end
            swud_pkg::ST_W_HI: begin
                mul_a = opa_reg;
                mul_b = {opb_reg[ACC_W-1], opb_reg[ACC_W-1:WORD_W]};
            end
            swud_pkg::ST_WRITE: mem_we = 1'b1;
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        ret_next       = ret_reg;
        clr_cnt_next   = clr_cnt_reg;
        wlo_next       = wlo_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        wres_next      = wres_reg;
        two_next       = two_reg;
        dot_next       = dot_reg;
        sq_next        = sq_reg;
        norm_next      = norm_reg;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            swud_pkg::ST_CLEAR: clr_cnt_next = clr_cnt_reg + IDX_W'(1);
            swud_pkg::ST_DOT_ACC: begin
                dot_next = dot_sum;
                // inner-product end: scale times the finished dot sum
                opa_next = {2'b00, scale_reg};
                opb_next = dot_sum;
                ret_next = swud_pkg::ST_DOT_OUT;
            end
            swud_pkg::ST_SQ_ACC: begin
                sq_next = swud_pkg::sat_add64(sq_reg, prod_reg[ACC_W-1:0]);
            end
            swud_pkg::ST_STEP_ACC: begin
                // step t = floor(multiplier * value / 2^16), then t * inverse scale
                opa_next = {2'b00, inv_reg};
                opb_next = {{(ACC_W-(PROD_W-FRAC_W)){prod_reg[PROD_W-1]}},
                            prod_reg[PROD_W-1:FRAC_W]};
                ret_next = swud_pkg::ST_WRITE;
            end
            swud_pkg::ST_W_HI:  wlo_next  = prod_reg;
            swud_pkg::ST_W_FIN: wres_next = swud_pkg::shr_sat(wide_sum);
            swud_pkg::ST_WRITE: begin
                opa_next = {2'b00, scale_reg};
                opb_next = dot_reg;
                ret_next = swud_pkg::ST_NORM_U;
            end
            swud_pkg::ST_NORM_U: begin
                two_next = swud_pkg::sat_add64(wres_reg, wres_reg);
                opa_next = {mulf_reg[WORD_W-1], mulf_reg};
                opb_next = sq_reg;
                ret_next = swud_pkg::ST_NORM_V;
            end
            swud_pkg::ST_NORM_V: begin
                opa_next = {mulf_reg[WORD_W-1], mulf_reg};
                opb_next = swud_pkg::sat_add64(wres_reg, two_reg);
                ret_next = swud_pkg::ST_NORM_ACC;
            end
            swud_pkg::ST_NORM_ACC: begin
                if (out_free) begin
                    norm_next      = swud_pkg::sat_add64(norm_reg, wres_reg);
                    out_data_next  = norm_next;
                    out_kind_next  = swud_pkg::KIND_NORM;
                    out_valid_next = 1'b1;
                    dot_next       = '0;
                    sq_next        = '0;
                end
            end
            swud_pkg::ST_DOT_OUT: begin
                if (out_free) begin
                    out_data_next  = wres_reg;
                    out_kind_next  = swud_pkg::KIND_DOT;
                    out_valid_next = 1'b1;
                    dot_next       = '0;
                    sq_next        = '0;
                end
            end
            default: begin
                ret_next = ret_reg;
            end
        endcase
    end

    // weight memory ports
    always_ff @(posedge aclk) begin
        if (mem_we) weight_mem[mem_waddr] <= mem_wdata;
        if (mem_re) rd_data_reg <= weight_mem[s_tdata[IDX_W-1:0]];
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= swud_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            dot_reg       <= '0;
            sq_reg        <= '0;
            norm_reg      <= '0;
            scale_reg     <= swud_pkg::SCALE_RESET;
            inv_reg       <= swud_pkg::INV_SCALE_RESET;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            dot_reg       <= dot_next;
            sq_reg        <= sq_next;
            norm_reg      <= norm_next;
            // configuration writes, unknown indexes ignored
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == swud_pkg::REG_SCALE)     scale_reg <= cfg_data[REG_W-1:0];
                if (cfg_index == swud_pkg::REG_INV_SCALE) inv_reg   <= cfg_data[REG_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_tuser;
            idx_reg  <= s_tdata[IDX_W-1:0];
            val_reg  <= s_tdata[IDX_W+WORD_W-1:IDX_W];
            mulf_reg <= s_tdata[IDX_W+2*WORD_W-1:IDX_W+WORD_W];
            last_reg <= s_tlast;
        end
        prod_reg     <= mul_a * mul_b;
        ret_reg      <= ret_next;
        wlo_reg      <= wlo_next;
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        wres_reg     <= wres_next;
        two_reg      <= two_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
    end

endmodule

// ----- bench/tb.sv -----
// self-checking testbench for the sparse weight update / inner product block
`timescale 1ns / 1ps

module tb;
    import swud_pkg::*;

    // run shape
    localparam int RESET_CYCLES    = 11;
    localparam int ITEMS_PER_PHASE = 322;
    localparam int PHASES          = 6;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 2_000_000;

    // Q16.16 constants used by the directed requests
    localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [31:0] Q_TWO   = 32'sh0002_0000;
    localparam logic signed [31:0] Q_THREE = 32'sh0003_0000;
    localparam logic signed [31:0] Q_HALF  = 32'sh0000_8000;
    localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ZERO  = 32'sh0;
    localparam logic signed [31:0] Q_ULP   = 32'sh1;

    // saturation bounds
    localparam acc_t ACC_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam acc_t ACC_LO = 64'sh8000_0000_0000_0000;
    localparam logic signed [ACC_W:0] WEIGHT_TOP    = 65'sh0_7FFF_FFFF;
    localparam logic signed [ACC_W:0] WEIGHT_BOTTOM = -65'sh0_8000_0000;

    // register indexes the block ignores
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = CFG_IDX_W'(255);

    typedef struct packed {
        logic                op;
        logic [IDX_W-1:0]    index;
        logic signed [31:0]  value;
        logic signed [31:0]  mult;
        logic                last;
    } sparse_req_t;

    typedef struct packed {
        acc_t value;
        logic kind;
    } sparse_result_t;

    typedef struct packed {
        sparse_req_t req;
        logic        has_want;
        acc_t        want;
        logic        want_kind;
    } dir_row_t;

    // directed requests; typed results only where they follow at once from reset state
    localparam int DIRECTED_ROWS = 20;
    localparam dir_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        '{'{OP_DOT,    16'h0000, Q_ONE,   Q_ONE,    1'b1}, 1'b1, 64'sh0,           KIND_DOT},
        '{'{OP_UPDATE, 16'h0005, Q_ONE,   Q_ONE,    1'b1}, 1'b1, 64'sh1_0000_0000, KIND_NORM},
        '{'{OP_DOT,    16'h0005, Q_ONE,   Q_ONE,    1'b1}, 1'b1, 64'sh1_0000_0000, KIND_DOT},
        '{'{OP_UPDATE, 16'hFFFF, Q_MAX,   Q_MAX,    1'b0}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_UPDATE, 16'hFFFF, Q_MIN,   Q_MIN,    1'b1}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_DOT,    16'hFFFF, Q_MIN,   Q_ZERO,   1'b0}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_DOT,    16'h0000, Q_MAX,   Q_ZERO,   1'b1}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_UPDATE, 16'h0001, Q_TWO,   Q_HALF,   1'b0}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_DOT,    16'h0005, -Q_ONE,  Q_ONE,    1'b0}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_UPDATE, 16'h0001, Q_THREE, -Q_THREE, 1'b1}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_UPDATE, 16'h0002, Q_ONE,   Q_ONE,    1'b0}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_DOT,    16'h0002, Q_ONE,   Q_ZERO,   1'b1}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_UPDATE, 16'h0007, Q_ONE,   Q_TWO,    1'b0}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_UPDATE, 16'h0007, Q_ONE,   Q_TWO,    1'b0}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_UPDATE, 16'h0007, Q_ONE,   Q_TWO,    1'b1}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_UPDATE, 16'h0008, Q_ZERO,  Q_ZERO,   1'b1}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_UPDATE, 16'h0009, Q_ONE,   Q_ZERO,   1'b1}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_UPDATE, 16'h8000, Q_MIN,   Q_MAX,    1'b1}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_DOT,    16'h8000, Q_MAX,   Q_MIN,    1'b1}, 1'b0, 64'sh0,           KIND_DOT},
        '{'{OP_UPDATE, 16'h0003, -Q_ULP,  Q_ULP,    1'b1}, 1'b0, 64'sh0,           KIND_DOT}
    };

    // register settings per random phase; the last phase draws its own
    localparam logic [31:0] SCALE_SETTINGS [PHASES] = '{
        32'h8001_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h0002_0000, 32'h0
    };
    localparam logic [31:0] INVERSE_SETTINGS [PHASES] = '{
        32'h0001_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_8000, 32'h0
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [ACC_W-1:0]      m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // mirror of the block state
    logic signed [31:0] weight_mirror [DEPTH];
    acc_t               norm_total;
    acc_t               dot_total;
    acc_t               square_total;
    logic [REG_W-1:0]   scale_reg;
    logic [REG_W-1:0]   inv_scale_reg;

    sparse_result_t awaited_results [$];

    int   mismatches   = 0;
    int   items_sent   = 0;
    int   vectors_sent = 0;
    int   norm_results = 0;
    int   dot_results  = 0;
    int   reg_writes   = 0;
    logic calm         = 1'b0;
    logic hold_off_req = 1'b0;

    sparse_weight_update_dot_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // signed 64-bit add, clamped
    function automatic acc_t clamp_add(input acc_t a, input acc_t b);
        logic signed [ACC_W:0] sum;
        sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            return sum[ACC_W] ? ACC_LO : ACC_HI;
        end
        return sum[ACC_W-1:0];
    endfunction

    // exact product shifted down by the fraction width with floor, clamped to 64 bits
    function automatic acc_t floor_mul_q16(input acc_t a, input acc_t b);
        logic signed [2*ACC_W-1:0] wa, wb, prod;
        wa = a;
        wb = b;
        prod = (wa * wb) >>> FRAC_W;
        if (prod > ACC_HI) begin
            return ACC_HI;
        end
        if (prod < ACC_LO) begin
            return ACC_LO;
        end
        return prod[ACC_W-1:0];
    endfunction

    // one sparse element: weight update, sums, and the norm or inner product on last
    function automatic logic compute_sparse_result(input sparse_req_t r, output acc_t res,
                                                   output logic kind);
        acc_t held, val, mul, step, delta, twice_dot, sq_term, sc, inv;
        logic signed [ACC_W:0] sum;
        held = weight_mirror[r.index];
        val  = r.value;
        mul  = r.mult;
        sc   = {33'd0, scale_reg};
        inv  = {33'd0, inv_scale_reg};
        res  = '0;
        kind = KIND_DOT;
        dot_total = clamp_add(dot_total, held * val);
        if (r.op == OP_UPDATE) begin
            step  = floor_mul_q16(mul, val);
            delta = floor_mul_q16(step, inv);
            square_total = clamp_add(square_total, val * val);
            sum = {delta[ACC_W-1], delta} + {held[ACC_W-1], held};
            if (sum > WEIGHT_TOP) begin
                weight_mirror[r.index] = Q_MAX;
            end else if (sum < WEIGHT_BOTTOM) begin
                weight_mirror[r.index] = Q_MIN;
            end else begin
                weight_mirror[r.index] = sum[31:0];
            end
        end
        if (!r.last) begin
            return 1'b0;
        end
        if (r.op == OP_UPDATE) begin
            twice_dot  = floor_mul_q16(sc, dot_total);
            twice_dot  = clamp_add(twice_dot, twice_dot);
            sq_term    = clamp_add(floor_mul_q16(mul, square_total), twice_dot);
            norm_total = clamp_add(norm_total, floor_mul_q16(mul, sq_term));
            res  = norm_total;
            kind = KIND_NORM;
        end else begin
            res  = floor_mul_q16(sc, dot_total);
            kind = KIND_DOT;
        end
        dot_total    = '0;
        square_total = '0;
        return 1'b1;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        if (calm) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 50);
    endfunction

    // Q16.16 operand: small magnitudes mostly, some full-range, some extremes
    function automatic logic signed [31:0] pick_q16();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            case ($urandom_range(0, 4))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return Q_ZERO;
                3: return -Q_ULP;
                default: return Q_ONE;
            endcase
        end
        if (roll < 3) begin
            return $urandom;
        end
        return $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
    endfunction

    // weight index: a small hot set so weights get revisited, plus the corners
    function automatic logic [IDX_W-1:0] pick_index();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) begin
            return IDX_W'($urandom_range(0, 63));
        end
        if (roll == 7) begin
            return IDX_W'($urandom);
        end
        if (roll == 8) begin
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        return 16'h8000 | IDX_W'($urandom_range(0, 15));
    endfunction

    // offer one request, predict on acceptance; entered and left at a falling edge
    task automatic offer_request(input sparse_req_t r, input logic has_want, input acc_t want,
                                 input logic want_kind);
        int             gap;
        sparse_result_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.mult, r.value, r.index};
        s_tuser  <= r.op;
        s_tlast  <= r.last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (compute_sparse_result(r, res.value, res.kind)) begin
            if (has_want) begin
                res.value = want;
                res.kind  = want_kind;
            end
            awaited_results.push_back(res);
        end
        items_sent++;
        if (r.last) begin
            vectors_sent++;
        end
        @(negedge aclk);
    endtask

    // register write over the configuration channel
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        if (idx == REG_SCALE) begin
            scale_reg = data[REG_W-1:0];
        end else if (idx == REG_INV_SCALE) begin
            inv_scale_reg = data[REG_W-1:0];
        end
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // wait for all results, then let the block finish any trailing work
    task automatic settle_block();
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // result sink: random bursts and stalls, one long hold-off on request
    initial begin : result_sink
        int burst, stall, n;
        @(negedge aclk);
        forever begin
            m_tready <= 1'b1;
            burst = calm ? 64 : $urandom_range(1, 20);
            repeat (burst) @(negedge aclk);
            stall = pick_gap();
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                for (n = 0; n < stall; n++) @(negedge aclk);
            end
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        sparse_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result %h kind %0d", $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: result mismatch: expected %h, got %h",
                             $time, want.value, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== want.kind) begin
                    $display("%0t: result kind mismatch: expected %0d, got %0d",
                             $time, want.kind, m_tuser);
                    mismatches++;
                end
                if (want.kind == KIND_NORM) begin
                    norm_results++;
                end else begin
                    dot_results++;
                end
            end
        end
    end

    // cycle limit
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
        $display("** sparse_weight_update_dot_top: FAILED **");
        $finish;
    end

    // reset, directed table, then random phases under changing register settings
    initial begin : stimulus
        int          i, k, len, mode, phase, phase_items;
        sparse_req_t r;
        for (i = 0; i < DEPTH; i++) begin
            weight_mirror[i] = '0;
        end
        norm_total    = '0;
        dot_total     = '0;
        square_total  = '0;
        scale_reg     = SCALE_RESET;
        inv_scale_reg = INV_SCALE_RESET;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, taken once the clearing pass is over
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            offer_request(DIRECTED_TABLE[i].req, DIRECTED_TABLE[i].has_want,
                          DIRECTED_TABLE[i].want, DIRECTED_TABLE[i].want_kind);
        end
        s_tvalid <= 1'b0;

        for (phase = 0; phase < PHASES; phase++) begin
            settle_block();
            calm = (phase == 3);
            if (phase == PHASES - 1) begin
                write_register(REG_SCALE, $urandom);
                write_register(REG_INV_SCALE, $urandom);
                write_register(REG_UNUSED, $urandom);
            end else begin
                write_register(REG_SCALE, SCALE_SETTINGS[phase]);
                write_register(REG_INV_SCALE, INVERSE_SETTINGS[phase]);
            end
            if (phase == 0) begin
                write_register(REG_UNUSED, $urandom);
                write_register(REG_TOP, $urandom);
            end
            // long receiver hold-off while requests keep coming
            if (phase == 2) begin
                hold_off_req = 1'b1;
            end

            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                k = $urandom_range(0, 19);
                len = (k < 16) ? $urandom_range(1, 6) :
                      (k < 19) ? $urandom_range(7, 16) : $urandom_range(17, 40);
                mode = $urandom_range(0, 19);
                for (k = 0; k < len; k++) begin
                    if (mode < 9) begin
                        r.op = OP_UPDATE;
                    end else if (mode < 17) begin
                        r.op = OP_DOT;
                    end else begin
                        r.op = $urandom_range(0, 1) ? OP_DOT : OP_UPDATE;
                    end
                    r.index = pick_index();
                    r.value = pick_q16();
                    r.mult  = pick_q16();
                    r.last  = (k == len - 1);
                    offer_request(r, 1'b0, '0, KIND_DOT);
                    phase_items++;
                end
            end
            s_tvalid <= 1'b0;
        end

        settle_block();
        if (awaited_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, awaited_results.size());
            mismatches++;
        end
        $display("run: %0d requests in %0d sparse vectors, %0d register writes over %0d settings",
                 items_sent, vectors_sent, reg_writes, PHASES + 1);
        $display("run: %0d norm updates and %0d inner products checked, %0d mismatches",
                 norm_results, dot_results, mismatches);
        if (mismatches == 0) begin
            $display("** sparse_weight_update_dot_top: PASSED **");
        end else begin
            $display("** sparse_weight_update_dot_top: FAILED **");
        end
        $finish;
    end

endmodule
